// ===== sv/mfu_pkg.sv =====
// Package: sizes, constants and shared types of the page replacement unit.
`timescale 1ns / 1ps
package mfu_pkg;

	localparam int MAX_FRAMES = 16;
	localparam int PAGE_BITS  = 16;
	localparam int IDX_W      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int NF_W       = $clog2(MAX_FRAMES + 1);
	localparam int CFG_W      = 5;
	localparam int CNT_W      = 16;
	localparam int FAULT_W    = 16;
	localparam int SLOT_W     = 4;

	localparam logic [CFG_W-1:0] NUM_FRAMES_RST = CFG_W'(4);
	localparam logic [CNT_W-1:0] COUNT_ONE      = CNT_W'(1);

	// Lookup token that walks the row of frame cells
	typedef struct packed {
		logic                 vld;
		logic [PAGE_BITS-1:0] page;
		logic                 found;
		logic [IDX_W-1:0]     found_idx;
		logic [CNT_W-1:0]     best_cnt;
		logic [IDX_W-1:0]     best_idx;
		logic [PAGE_BITS-1:0] best_page;
	} token_t;

	// Update broadcast to the cells once an item is resolved
	typedef struct packed {
		logic                 en;
		logic                 fill;
		logic [IDX_W-1:0]     idx;
		logic [PAGE_BITS-1:0] page;
	} upd_t;

endpackage

// ===== sv/mfu_if.sv =====
// Interfaces: request, result and configuration channels.
`timescale 1ns / 1ps
interface mfu_req_if;
	logic                          valid;
	logic                          ready;
	logic [mfu_pkg::PAGE_BITS-1:0] page;
	modport source (output valid, output page, input ready);
	modport sink (input valid, input page, output ready);
endinterface

interface mfu_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          hit;
	logic [mfu_pkg::SLOT_W-1:0]    slot;
	logic                          evicted_valid;
	logic [mfu_pkg::PAGE_BITS-1:0] evicted_page;
	logic [mfu_pkg::FAULT_W-1:0]   fault_total;
	modport source (output valid, output hit, output slot, output evicted_valid,
		output evicted_page, output fault_total, input ready);
	modport sink (input valid, input hit, input slot, input evicted_valid,
		input evicted_page, input fault_total, output ready);
endinterface

interface mfu_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [mfu_pkg::CFG_W-1:0] num_frames;
	modport source (output valid, output num_frames, input ready);
	modport sink (input valid, input num_frames, output ready);
endinterface

// ===== sv/mfu_cell.sv =====
// Frame cell: holds one frame and folds its match and use count into the token.
`timescale 1ns / 1ps
module mfu_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [mfu_pkg::IDX_W-1:0] cell_idx,
	input  logic [mfu_pkg::NF_W-1:0]  active_n,
	input  mfu_pkg::token_t           tin,
	output mfu_pkg::token_t           tout,
	input  mfu_pkg::upd_t             upd
);
	import mfu_pkg::*;

	logic                 valid_q;
	logic [PAGE_BITS-1:0] page_q;
	logic [CNT_W-1:0]     count_q;
	logic                 in_range;
	logic                 match;
	logic                 better;
	logic                 sel;
	token_t               tnext;

	assign in_range = NF_W'(cell_idx) < active_n;
	assign match    = in_range && valid_q && (page_q == tin.page) && !tin.found;
	assign better   = in_range && ((cell_idx == '0) || (count_q >= tin.best_cnt));
	assign sel      = upd.en && (upd.idx == cell_idx);

	// Fold this frame into the passing token
	always_comb begin
		tnext = tin;
		if (match) begin
			tnext.found     = 1'b1;
			tnext.found_idx = cell_idx;
		end
		if (better) begin
			tnext.best_cnt  = count_q;
			tnext.best_idx  = cell_idx;
			tnext.best_page = page_q;
		end
	end

	// Hand the token to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tout <= '0;
		end else begin
			tout <= tnext;
		end
	end

	// Valid bit of the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (sel && upd.fill) begin
			valid_q <= 1'b1;
		end
	end

	// Frame contents: refill or bump the saturating use count
	always_ff @(posedge clk) begin
		if (sel) begin
			if (upd.fill) begin
				page_q  <= upd.page;
				count_q <= COUNT_ONE;
			end else if (count_q != '1) begin
				count_q <= count_q + COUNT_ONE;
			end
		end
	end

endmodule

// ===== sv/mfu_page_replacement.sv =====
// Top level: most-frequently-used page replacement unit with a row of frame cells.
//
// Usage:
//   req carries one page reference per item (valid/ready). rsp returns one result
//   per item: hit, slot holding the page, evicted_valid/evicted_page for a
//   replacement, and the saturating fault total. cfg writes num_frames (0 acts as
//   1, values above the built frame count act as that count); write it only idle.
// Timing:
//   An accepted item enters a lookup token that walks the row of MAX_FRAMES
//   cells, one cell per cycle, collecting the first match and the frame with the
//   highest use count (ties to the higher index). The sequencer registers the
//   result when the token leaves the last cell and loads it into the output
//   register once that register is free; the next item is accepted only after
//   that, so one item at a time walks the cell row.
// Reset:
//   Clears all frame valid bits, the fill pointer, the fault counter and sets
//   num_frames to 4. No clearing pass is needed.
// Stall:
//   A result waits in the output register; a finished lookup holds until that
//   register is free, and a new item is accepted while a result waits.
`timescale 1ns / 1ps
module mfu_page_replacement (
	input  logic      clk,
	input  logic      arst_n,
	mfu_req_if.sink   req,
	mfu_rsp_if.source rsp,
	mfu_cfg_if.sink   cfg
);
	import mfu_pkg::*;

	localparam int AW = (CFG_W > NF_W) ? CFG_W : NF_W;

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_t;

	state_t               state_q;
	logic [CFG_W-1:0]     num_frames_q;
	logic [NF_W-1:0]      n_q;
	logic [NF_W-1:0]      fill_q;
	logic [FAULT_W-1:0]   fault_q;
	token_t               tok_q;
	upd_t                 upd_q;
	logic                 res_hit_q;
	logic [IDX_W-1:0]     res_slot_q;
	logic                 res_ev_q;
	logic [PAGE_BITS-1:0] res_ev_page_q;
	logic [PAGE_BITS-1:0] res_page_q;
	logic                 out_valid_q;
	logic                 out_hit_q;
	logic [SLOT_W-1:0]    out_slot_q;
	logic                 out_ev_q;
	logic [PAGE_BITS-1:0] out_ev_page_q;
	logic [FAULT_W-1:0]   out_fault_q;

	logic [AW-1:0]        nf_ext;
	logic [NF_W-1:0]      active_n;
	token_t               chain [MAX_FRAMES+1];
	token_t               tail;
	token_t               tok_new;
	upd_t                 upd_new;
	logic                 accept;
	logic                 out_free;
	logic                 deliver;

	// Clamp the configured frame count
	assign nf_ext = AW'(num_frames_q);
	always_comb begin
		if (nf_ext == '0) begin
			active_n = NF_W'(1);
		end else if (nf_ext > AW'(MAX_FRAMES)) begin
			active_n = NF_W'(MAX_FRAMES);
		end else begin
			active_n = NF_W'(nf_ext);
		end
	end

	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;
	assign deliver   = (state_q == ST_DONE) && out_free;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_frames_q <= NUM_FRAMES_RST;
		end else if (cfg.valid) begin
			num_frames_q <= cfg.num_frames;
		end
	end

	// Build the fresh token and the frame update
	always_comb begin
		tok_new      = '0;
		tok_new.vld  = 1'b1;
		tok_new.page = req.page;
		upd_new      = '0;
		upd_new.en   = 1'b1;
		upd_new.fill = !res_hit_q;
		upd_new.idx  = res_slot_q;
		upd_new.page = res_page_q;
	end

	// Inject a token for each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else if (accept) begin
			tok_q <= tok_new;
		end else begin
			tok_q <= '0;
		end
	end

	// Broadcast the frame update for one cycle when the result is delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upd_q <= '0;
		end else if (deliver) begin
			upd_q <= upd_new;
		end else begin
			upd_q <= '0;
		end
	end

	// Output valid: set on delivery, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (deliver) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Row of frame cells
	assign chain[0] = tok_q;
	for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
		mfu_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (IDX_W'(i)),
			.active_n (n_q),
			.tin      (chain[i]),
			.tout     (chain[i+1]),
			.upd      (upd_q)
		);
	end
	assign tail = chain[MAX_FRAMES];

	// Sequencer: accept, resolve at the tail, update counters and deliver
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			n_q           <= NF_W'(1);
			fill_q        <= '0;
			fault_q       <= '0;
			res_hit_q     <= 1'b0;
			res_slot_q    <= '0;
			res_ev_q      <= 1'b0;
			res_ev_page_q <= '0;
			res_page_q    <= '0;
			out_hit_q     <= 1'b0;
			out_slot_q    <= '0;
			out_ev_q      <= 1'b0;
			out_ev_page_q <= '0;
			out_fault_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						res_page_q <= req.page;
						n_q        <= active_n;
						state_q    <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (tail.vld) begin
						if (tail.found) begin
							res_hit_q     <= 1'b1;
							res_slot_q    <= tail.found_idx;
							res_ev_q      <= 1'b0;
							res_ev_page_q <= '0;
						end else if (fill_q < n_q) begin
							res_hit_q     <= 1'b0;
							res_slot_q    <= fill_q[IDX_W-1:0];
							res_ev_q      <= 1'b0;
							res_ev_page_q <= '0;
						end else begin
							res_hit_q     <= 1'b0;
							res_slot_q    <= tail.best_idx;
							res_ev_q      <= 1'b1;
							res_ev_page_q <= tail.best_page;
						end
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						if (!res_hit_q && !res_ev_q) begin
							fill_q <= fill_q + NF_W'(1);
						end
						if (!res_hit_q && (fault_q != '1)) begin
							fault_q     <= fault_q + FAULT_W'(1);
							out_fault_q <= fault_q + FAULT_W'(1);
						end else begin
							out_fault_q <= fault_q;
						end
						out_hit_q     <= res_hit_q;
						out_slot_q    <= SLOT_W'(res_slot_q);
						out_ev_q      <= res_ev_q;
						out_ev_page_q <= res_ev_page_q;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Drive the result channel
	assign rsp.valid         = out_valid_q;
	assign rsp.hit           = out_hit_q;
	assign rsp.slot          = out_slot_q;
	assign rsp.evicted_valid = out_ev_q;
	assign rsp.evicted_page  = out_ev_page_q;
	assign rsp.fault_total   = out_fault_q;

endmodule

// ===== sim/mfu_replacement_checker.sv =====
// Checker: predicts each page lookup outcome and compares it with the unit's results.
`timescale 1ns / 1ps
module mfu_replacement_checker (
	input  logic clk,
	input  logic arst_n,
	mfu_req_if   req,
	mfu_rsp_if   rsp,
	mfu_cfg_if   cfg,
	output int   fail_count,
	output int   outstanding
);
	import mfu_pkg::*;

	typedef struct packed {
		logic                 hit;
		logic [SLOT_W-1:0]    slot;
		logic                 ev_valid;
		logic [PAGE_BITS-1:0] ev_page;
		logic [FAULT_W-1:0]   fault_total;
	} page_outcome_t;

	// Predicted frame table and counters
	logic [CFG_W-1:0]     frames_cfg;
	logic                 resident [MAX_FRAMES];
	logic [PAGE_BITS-1:0] frame_pg [MAX_FRAMES];
	logic [CNT_W-1:0]     use_cnt  [MAX_FRAMES];
	int                   fill_ptr;
	logic [FAULT_W-1:0]   faults;

	page_outcome_t results_due [$];

	initial fail_count = 0;

	// Look up one page, update the predicted table and return the outcome
	function automatic page_outcome_t resolve_page(input logic [PAGE_BITS-1:0] pg);
		page_outcome_t o;
		int n;
		int hit_idx;
		int victim;
		o = '0;
		n = (frames_cfg == 0) ? 1 : (int'(frames_cfg) > MAX_FRAMES) ? MAX_FRAMES : int'(frames_cfg);
		hit_idx = -1;
		// lowest matching frame wins when a page sits in two frames
		for (int i = 0; i < n; i++)
			if (hit_idx < 0 && resident[i] && frame_pg[i] == pg)
				hit_idx = i;
		if (hit_idx >= 0) begin
			o.hit  = 1'b1;
			o.slot = SLOT_W'(hit_idx);
			if (use_cnt[hit_idx] != '1)
				use_cnt[hit_idx] = use_cnt[hit_idx] + 1'b1;
		end else begin
			if (fill_ptr < n) begin
				victim   = fill_ptr;
				fill_ptr = fill_ptr + 1;
			end else begin
				// highest count goes, ties to the higher index
				victim = 0;
				for (int i = 1; i < n; i++)
					if (use_cnt[i] >= use_cnt[victim])
						victim = i;
				o.ev_valid = 1'b1;
				o.ev_page  = frame_pg[victim];
			end
			resident[victim] = 1'b1;
			frame_pg[victim] = pg;
			use_cnt[victim]  = COUNT_ONE;
			if (faults != '1)
				faults = faults + 1'b1;
			o.slot = SLOT_W'(victim);
		end
		o.fault_total = faults;
		return o;
	endfunction

	task automatic check_field(input string field, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			fail_count = fail_count + 1;
			if (fail_count <= 10)
				$display("mismatch in %s: expected %h, got %h", field, want, got);
		end
	endtask

	// Compare results first, then take config writes and new items
	always @(posedge clk or negedge arst_n) begin
		page_outcome_t want;
		if (!arst_n) begin
			frames_cfg = NUM_FRAMES_RST;
			for (int i = 0; i < MAX_FRAMES; i++) begin
				resident[i] = 1'b0;
				frame_pg[i] = '0;
				use_cnt[i]  = '0;
			end
			fill_ptr = 0;
			faults   = '0;
			results_due.delete();
			outstanding <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (results_due.size() == 0) begin
					fail_count = fail_count + 1;
					if (fail_count <= 10)
						$display("result with no item pending: hit=%b slot=%0d ev=%b/%h faults=%0d",
							rsp.hit, rsp.slot, rsp.evicted_valid, rsp.evicted_page,
							rsp.fault_total);
				end else begin
					want = results_due.pop_front();
					check_field("hit", 32'(want.hit), 32'(rsp.hit));
					check_field("slot", 32'(want.slot), 32'(rsp.slot));
					check_field("evicted_valid", 32'(want.ev_valid), 32'(rsp.evicted_valid));
					check_field("evicted_page", 32'(want.ev_page), 32'(rsp.evicted_page));
					check_field("fault_total", 32'(want.fault_total), 32'(rsp.fault_total));
				end
			end
			if (cfg.valid && cfg.ready)
				frames_cfg = cfg.num_frames;
			if (req.valid && req.ready)
				results_due.push_back(resolve_page(req.page));
			outstanding <= results_due.size();
		end
	end

endmodule

// ===== sim/testbench.sv =====
// Testbench top: clock, reset, page reference stimulus, result stalls and verdict.
`timescale 1ns / 1ps
module testbench;
	import mfu_pkg::*;

	localparam int RANDOM_ITEMS = 1030;
	localparam int SETTLE       = MAX_FRAMES + 4;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   outstanding;
	int   idle_pct;

	mfu_req_if req_ch ();
	mfu_rsp_if rsp_ch ();
	mfu_cfg_if cfg_ch ();

	mfu_page_replacement dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	mfu_replacement_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.cfg         (cfg_ch),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Offer one page; hold it until accepted, with an optional gap first
	task automatic send_page(input logic [PAGE_BITS-1:0] pg);
		if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.page  <= pg;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	// Drain all pending results, then write the frame count
	task automatic write_frames(input logic [CFG_W-1:0] v);
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (2) @(posedge clk);
		cfg_ch.valid      <= 1'b1;
		cfg_ch.num_frames <= v;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Stall the result side in random bursts
	initial begin
		int hold;
		hold = 0;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold = hold - 1;
				rsp_ch.ready <= 1'b0;
			end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct / 4) begin
				hold = $urandom_range(1, 12) - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		logic [PAGE_BITS-1:0] pool [$];
		logic [PAGE_BITS-1:0] pg;
		logic [CFG_W-1:0]     nf;
		int sent;
		int active;
		int len;
		int roll;
		int idx;
		bit final_phase;

		arst_n            <= 1'b0;
		req_ch.valid      <= 1'b0;
		req_ch.page       <= '0;
		cfg_ch.valid      <= 1'b0;
		cfg_ch.num_frames <= '0;
		idle_pct = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset frame count, page zero on empty frames, fill and evict
		idle_pct = 20;
		send_page(16'h0000);
		send_page(16'h0000);
		send_page(16'hFFFF);
		send_page(16'h1234);
		send_page(16'hABCD);
		send_page(16'hFFFF);
		send_page(16'h5555);
		send_page(16'hAAAA);
		// shrink: pages above the active count drop out of sight
		write_frames(CFG_W'(2));
		send_page(16'h0F0F);
		send_page(16'h1234);
		// count above the built size acts as the maximum; duplicate resident hits lowest
		write_frames(CFG_W'(31));
		send_page(16'h1234);
		send_page(16'h8001);
		// zero frames acts as one
		write_frames(CFG_W'(0));
		send_page(16'h7FFE);
		send_page(16'h7FFE);
		send_page(16'h0001);
		write_frames(CFG_W'(16));
		send_page(16'h0001);
		send_page(16'hFFFF);
		send_page(16'h8000);
		write_frames(CFG_W'(17));
		send_page(16'h8000);
		send_page(16'h4242);
		write_frames(CFG_W'(1));
		send_page(16'h4242);
		send_page(16'h2424);

		// Random phases: working set per phase, some noise, varied frame counts
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			final_phase = (RANDOM_ITEMS - sent) <= 150;
			if (final_phase) begin
				idle_pct = 0;
			end else begin
				case ($urandom_range(0, 3))
					0: idle_pct = 0;
					1: idle_pct = 10;
					2: idle_pct = 35;
					default: idle_pct = 70;
				endcase
			end
			case ($urandom_range(0, 9))
				0: nf = CFG_W'(0);
				1: nf = CFG_W'(1);
				2: nf = CFG_W'(16);
				3: nf = CFG_W'($urandom_range(17, 31));
				default: nf = CFG_W'($urandom_range(2, 15));
			endcase
			write_frames(nf);
			active = (nf == 0) ? 1 : (int'(nf) > MAX_FRAMES) ? MAX_FRAMES : int'(nf);
			pool.delete();
			repeat (active + $urandom_range(0, 4))
				pool.push_back(PAGE_BITS'($urandom()));
			len = final_phase ? RANDOM_ITEMS - sent : $urandom_range(40, 140);
			repeat (len) begin
				roll = $urandom_range(0, 99);
				if (roll < 80) begin
					// favor the low end of the pool so use counts spread apart
					idx = $urandom_range(0, pool.size() - 1);
					if ($urandom_range(0, 1) == 1)
						idx = idx / 2;
					pg = pool[idx];
				end else if (roll < 93) begin
					pg = PAGE_BITS'($urandom());
				end else if (roll < 96) begin
					pg = '0;
				end else begin
					pg = '1;
				end
				send_page(pg);
				sent = sent + 1;
			end
		end

		// Drain and give the verdict
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0 && outstanding == 0) begin
			$display("PASS mfu_page_replacement");
		end else begin
			$display("FAIL mfu_page_replacement");
		end
		$finish;
	end

	// Hard stop for a hung run
	initial begin
		#1000000;
		$display("FAIL mfu_page_replacement");
		$finish;
	end

endmodule

// ===== mfu_page_replacement.f =====
sv/mfu_pkg.sv
sv/mfu_if.sv
sv/mfu_cell.sv
sv/mfu_page_replacement.sv
sim/mfu_replacement_checker.sv
sim/testbench.sv
